FILE: rtl/vpva_pkg.sv
// package: sizes, codes, command and status types for the volume profile value area core
`default_nettype none
package vpva_pkg;

  localparam int unsigned BINS   = 1024;
  localparam int unsigned ADDR_W = $clog2(BINS);
  localparam int unsigned TICK_W = 20;
  localparam int unsigned VOL_W  = 24;
  localparam int unsigned BIN_W  = 40;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned Q_W    = 11;
  localparam int unsigned TGT_W  = TOT_W + Q_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_AREA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICE_BASE = 2'd1;
  localparam logic [Q_W-1:0]       Q10_RESET      = 11'd717;

  localparam logic [BIN_W-1:0]  BIN_MAX  = {BIN_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};
  localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(BINS - 1);

  typedef enum logic [3:0] {
    ST_RCLR, ST_IDLE, ST_DISPATCH, ST_CLR, ST_UPD_RD, ST_UPD_WR, ST_CHECK,
    ST_SCAN0, ST_SCAN, ST_INIT, ST_FL0, ST_FL, ST_FR0, ST_FR, ST_STEP, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_UPD_RD, OP_UPD_WR, OP_SCAN0, OP_SCAN, OP_INIT,
    OP_FL0, OP_FL, OP_FR0, OP_FR, OP_STEP, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic new_sess;
    logic oor;
    logic empty;
    logic at_edge;
    logic find_done;
    logic more;
    logic take_right;
    logic out_free;
  } status_t;

  function automatic logic [BIN_W-1:0] sat_bin(logic [BIN_W-1:0] a, logic [VOL_W-1:0] b);
    logic [BIN_W:0] s;
    s = {1'b0, a} + {{(BIN_W + 1 - VOL_W){1'b0}}, b};
    return s[BIN_W] ? BIN_MAX : s[BIN_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(logic [TOT_W-1:0] a, logic [BIN_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {{(TOT_W + 1 - BIN_W){1'b0}}, b};
    return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vpva_ctrl.sv
// controller: sequences clear, update, poc scan and value area growth
`default_nettype none
module vpva_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  vpva_pkg::status_t     st_i,
  output vpva_pkg::cmd_t        cmd_o
);
  import vpva_pkg::*;

  state_e state_q, state_d;
  logic   first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RCLR;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_RCLR: begin
        cmd_o.op = OP_CLR;
        if (st_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st_i.new_sess) state_d = ST_CLR;
        else if (st_i.oor) state_d = ST_CHECK;
        else               state_d = ST_UPD_RD;
      end
      ST_CLR: begin
        cmd_o.op = OP_CLR;
        if (st_i.sweep_last) state_d = st_i.oor ? ST_CHECK : ST_UPD_RD;
      end
      ST_UPD_RD: begin
        cmd_o.op = OP_UPD_RD;
        state_d  = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.op = OP_UPD_WR;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = st_i.empty ? ST_OUT : ST_SCAN0;
      end
      ST_SCAN0: begin
        cmd_o.op = OP_SCAN0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (st_i.sweep_last) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        first_d  = 1'b1;
        state_d  = ST_FL0;
      end
      ST_FL0: begin
        cmd_o.op = OP_FL0;
        if (st_i.at_edge) begin
          first_d = 1'b0;
          state_d = first_q ? ST_FR0 : ST_STEP;
        end else begin
          state_d = ST_FL;
        end
      end
      ST_FL: begin
        cmd_o.op = OP_FL;
        if (st_i.find_done) begin
          first_d = 1'b0;
          state_d = first_q ? ST_FR0 : ST_STEP;
        end
      end
      ST_FR0: begin
        cmd_o.op = OP_FR0;
        state_d  = st_i.at_edge ? ST_STEP : ST_FR;
      end
      ST_FR: begin
        cmd_o.op = OP_FR;
        if (st_i.find_done) state_d = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.op = OP_STEP;
        if (!st_i.more)          state_d = ST_OUT;
        else if (st_i.take_right) state_d = ST_FR0;
        else                      state_d = ST_FL0;
      end
      ST_OUT: begin
        cmd_o.op = OP_OUT;
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/vpva_dp.sv
// datapath: histogram memory, config registers, poc and value area registers, result word
`default_nettype none
module vpva_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  vpva_pkg::cmd_t                      cmd_i,
  output vpva_pkg::status_t                   st_o,
  input  wire logic                           cfg_valid_i,
  input  wire logic [vpva_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vpva_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           new_session_i,
  input  wire logic [vpva_pkg::TICK_W-1:0]    close_tick_i,
  input  wire logic [vpva_pkg::VOL_W-1:0]     bar_volume_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [vpva_pkg::TICK_W-1:0]         poc_tick_o,
  output logic [vpva_pkg::TICK_W-1:0]         vah_tick_o,
  output logic [vpva_pkg::TICK_W-1:0]         val_tick_o,
  output logic                                profile_empty_o,
  output logic                                out_of_range_o
);
  import vpva_pkg::*;

  // memory word: presence mark on top of bin sum
  logic [BIN_W:0] mem [BINS];
  logic [BIN_W:0] rdata_q;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [BIN_W:0]    wdata;
  logic              we;

  logic [Q_W-1:0]    q10_q;
  logic [TICK_W-1:0] base_q;
  logic              ns_q, oor_q;
  logic [VOL_W-1:0]  vol_q;
  logic [ADDR_W-1:0] k_q;
  logic [TOT_W-1:0]  total_q;
  logic [ADDR_W-1:0] sp_q;
  logic [BIN_W-1:0]  best_q, lvol_q, rvol_q;
  logic              have_q, lok_q, rok_q;
  logic [ADDR_W-1:0] poc_q, lo_q, hi_q, lcand_q, rcand_q;
  logic [TOT_W-1:0]  cur_q;
  logic [TGT_W-1:0]  target_q;
  logic              out_valid_q;

  logic              r_pres;
  logic [BIN_W-1:0]  r_vol;
  logic [TICK_W:0]   diff;
  logic              in_win;
  logic              more, take_right, out_free;

  assign r_pres = rdata_q[BIN_W];
  assign r_vol  = rdata_q[BIN_W-1:0];
  assign diff   = {1'b0, close_tick_i} - {1'b0, base_q};
  assign in_win = !diff[TICK_W] && (diff[TICK_W-1:0] < TICK_W'(BINS));

  assign more = ({1'b0, cur_q, 10'b0} < target_q) && (lok_q || rok_q);
  assign take_right = rok_q && (!lok_q || (rvol_q >= lvol_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    raddr = sp_q;
    we    = 1'b0;
    waddr = sp_q;
    wdata = '0;
    case (cmd_i.op)
      OP_CLR: we = 1'b1;
      OP_UPD_RD: raddr = k_q;
      OP_UPD_WR: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = {1'b1, sat_bin(r_vol, vol_q)};
      end
      OP_SCAN0: raddr = '0;
      OP_SCAN:  raddr = sp_q + 1'b1;
      OP_FL0:   raddr = lo_q - 1'b1;
      OP_FL:    raddr = sp_q - 1'b1;
      OP_FR0:   raddr = hi_q + 1'b1;
      OP_FR:    raddr = sp_q + 1'b1;
      default: raddr = sp_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    st_o.sweep_last = (sp_q == ADDR_TOP);
    st_o.new_sess   = ns_q;
    st_o.oor        = oor_q;
    st_o.empty      = (total_q == '0);
    st_o.at_edge    = (cmd_i.op == OP_FL0) ? (lo_q == '0) : (hi_q == ADDR_TOP);
    st_o.find_done  = r_pres || ((cmd_i.op == OP_FL) ? (sp_q == '0) : (sp_q == ADDR_TOP));
    st_o.more       = more;
    st_o.take_right = take_right;
    st_o.out_free   = out_free;
  end

  // config and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q10_q       <= Q10_RESET;
      base_q      <= '0;
      sp_q        <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_VALUE_AREA: q10_q  <= cfg_data_i[Q_W-1:0];
          CFG_PRICE_BASE: base_q <= cfg_data_i;
          default: ;
        endcase
      end
      // new result takes the register as the old one leaves
      if ((cmd_i.op == OP_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD:   sp_q <= '0;
        OP_CLR: begin
          sp_q    <= sp_q + 1'b1;
          total_q <= '0;
        end
        OP_UPD_WR: total_q <= sat_tot(total_q, {{(BIN_W - VOL_W){1'b0}}, vol_q});
        OP_SCAN0:  sp_q <= '0;
        OP_SCAN:   sp_q <= sp_q + 1'b1;
        OP_FL0:    sp_q <= lo_q - 1'b1;
        OP_FL:     sp_q <= sp_q - 1'b1;
        OP_FR0:    sp_q <= hi_q + 1'b1;
        OP_FR:     sp_q <= sp_q + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        ns_q  <= new_session_i;
        oor_q <= !in_win;
        vol_q <= bar_volume_i;
        k_q   <= diff[ADDR_W-1:0];
      end
      OP_SCAN0: have_q <= 1'b0;
      OP_SCAN: begin
        if (r_pres && (!have_q || r_vol > best_q)) begin
          best_q <= r_vol;
          poc_q  <= sp_q;
          have_q <= 1'b1;
        end
      end
      OP_INIT: begin
        cur_q    <= {{(TOT_W - BIN_W){1'b0}}, best_q};
        lo_q     <= poc_q;
        hi_q     <= poc_q;
        target_q <= total_q * q10_q;
      end
      OP_FL0: if (lo_q == '0) lok_q <= 1'b0;
      OP_FL: begin
        if (r_pres) begin
          lok_q   <= 1'b1;
          lcand_q <= sp_q;
          lvol_q  <= r_vol;
        end else if (sp_q == '0) begin
          lok_q <= 1'b0;
        end
      end
      OP_FR0: if (hi_q == ADDR_TOP) rok_q <= 1'b0;
      OP_FR: begin
        if (r_pres) begin
          rok_q   <= 1'b1;
          rcand_q <= sp_q;
          rvol_q  <= r_vol;
        end else if (sp_q == ADDR_TOP) begin
          rok_q <= 1'b0;
        end
      end
      OP_STEP: begin
        if (more) begin
          if (take_right) begin
            cur_q <= sat_tot(cur_q, rvol_q);
            hi_q  <= rcand_q;
          end else begin
            cur_q <= sat_tot(cur_q, lvol_q);
            lo_q  <= lcand_q;
          end
        end
      end
      OP_OUT: begin
        if (out_free) begin
          out_of_range_o  <= oor_q;
          profile_empty_o <= (total_q == '0);
          if (total_q == '0) begin
            poc_tick_o <= '0;
            vah_tick_o <= '0;
            val_tick_o <= '0;
          end else begin
            poc_tick_o <= base_q + {{(TICK_W - ADDR_W){1'b0}}, poc_q};
            vah_tick_o <= base_q + {{(TICK_W - ADDR_W){1'b0}}, hi_q};
            val_tick_o <= base_q + {{(TICK_W - ADDR_W){1'b0}}, lo_q};
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/volume_profile_value_area_core.sv
// top level: session volume profile with point of control and value area
`default_nettype none
//  channel  direction  handshake              payload
//  s_axis   in         tvalid / tready        tdata: close_tick, bar_volume; tuser: new_session
//  m_axis   out        tvalid / tready        tdata: poc, vah, val; tuser: empty, out_of_range
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  after reset a clearing pass sweeps every word of the histogram memory, no word taken
//  one word runs alone: load and dispatch, a clear pass on a new session, an update read
//  and write unless out of range, a poc scan over the single memory read port, then a
//  search left or right and a step while the value area grows; an empty profile skips to output
//  a finished word waits in the output register while the next input word is taken
//  cfg_ready is always high, writes are meant only while the core is idle
module volume_profile_value_area_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // close_tick[19:0], bar_volume[43:20], zero
  input  wire logic [0:0]  s_axis_tuser_i,   // new_session[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // poc_tick[19:0], vah_tick[39:20], val_tick[59:40]
  output logic [1:0]       m_axis_tuser_o,   // profile_empty[0], out_of_range[1]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i
);
  import vpva_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic [TICK_W-1:0] poc, vah, val;
  logic              empty, oor;

  // controller sees status and the input valid, datapath sees commands and the data ports
  vpva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  vpva_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .new_session_i   (s_axis_tuser_i[0]),
    .close_tick_i    (s_axis_tdata_i[19:0]),
    .bar_volume_i    (s_axis_tdata_i[43:20]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .poc_tick_o      (poc),
    .vah_tick_o      (vah),
    .val_tick_o      (val),
    .profile_empty_o (empty),
    .out_of_range_o  (oor)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {4'b0, val, vah, poc};
  assign m_axis_tuser_o = {oor, empty};

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// testbench for the volume profile value area core: bar stream checked against a session model
`timescale 1ns / 1ps

import vpva_pkg::*;

// one expected set of levels for one bar
typedef struct {
  logic [TICK_W-1:0] poc;
  logic [TICK_W-1:0] vah;
  logic [TICK_W-1:0] val;
  logic              empty;
  logic              oor;
} levels_t;

// session histogram model and store of pending levels
class profile_scoreboard;
  logic [Q_W-1:0]    frac_q10;
  logic [TICK_W-1:0] base_tick;
  logic [BIN_W-1:0]  bin_vol [BINS];
  bit                bin_seen [BINS];
  logic [TOT_W-1:0]  sess_total;
  levels_t           pending_levels[$];

  function void clear_session();
    foreach (bin_vol[i]) begin
      bin_vol[i]  = '0;
      bin_seen[i] = 1'b0;
    end
    sess_total = '0;
  endfunction

  function void reset_state();
    frac_q10  = Q10_RESET;
    base_tick = '0;
    clear_session();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_VALUE_AREA) frac_q10 = data[Q_W-1:0];
    else if (idx == CFG_PRICE_BASE) base_tick = data[TICK_W-1:0];
  endfunction

  // append one expected set at the tail
  function void queue_levels(levels_t lv);
    pending_levels = {pending_levels, lv};
  endfunction

  // nearest marked bin strictly below / above pos
  function bit seek_down(int pos, output int at);
    for (int k = pos - 1; k >= 0; k--)
      if (bin_seen[k]) begin
        at = k;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function bit seek_up(int pos, output int at);
    for (int k = pos + 1; k < BINS; k++)
      if (bin_seen[k]) begin
        at = k;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function void note_bar(bit new_sess, logic [TICK_W-1:0] tick, logic [VOL_W-1:0] vol);
    levels_t          lv;
    logic [TICK_W:0]  off;
    logic [BIN_W:0]   bsum;
    logic [TOT_W:0]   tsum;
    logic [63:0]      target, cur;
    logic [BIN_W-1:0] best;
    int               poc, lo, hi, lc, rc, k;
    bit               lok, rok, take_r;
    if (new_sess) clear_session();
    lv.oor = 1'b1;
    off = {1'b0, tick} - {1'b0, base_tick};
    if (tick >= base_tick && off < BINS) begin
      k = int'(off);
      bsum = {1'b0, bin_vol[k]} + (BIN_W+1)'(vol);
      bin_vol[k] = bsum[BIN_W] ? BIN_MAX : bsum[BIN_W-1:0];
      bin_seen[k] = 1'b1;
      tsum = {1'b0, sess_total} + (TOT_W+1)'(vol);
      sess_total = tsum[TOT_W] ? TOT_MAX : tsum[TOT_W-1:0];
      lv.oor = 1'b0;
    end
    if (sess_total == 0) begin
      lv.poc = '0; lv.vah = '0; lv.val = '0; lv.empty = 1'b1;
      queue_levels(lv);
      return;
    end
    // lowest bin with the largest volume among marked bins
    poc = -1;
    best = '0;
    for (int i = 0; i < BINS; i++)
      if (bin_seen[i] && (poc < 0 || bin_vol[i] > best)) begin
        best = bin_vol[i];
        poc = i;
      end
    target = 64'(sess_total) * 64'(frac_q10);
    cur = 64'(bin_vol[poc]);
    lo = poc;
    hi = poc;
    lok = seek_down(lo, lc);
    rok = seek_up(hi, rc);
    while ((cur << 10) < target && (lok || rok)) begin
      take_r = rok && (!lok || bin_vol[rc] >= bin_vol[lc]);
      if (take_r) begin
        cur = cur + 64'(bin_vol[rc]);
        hi = rc;
        rok = seek_up(hi, rc);
      end else begin
        cur = cur + 64'(bin_vol[lc]);
        lo = lc;
        lok = seek_down(lo, lc);
      end
      if (cur > 64'(TOT_MAX)) cur = 64'(TOT_MAX);
    end
    lv.poc = base_tick + TICK_W'(poc);
    lv.vah = base_tick + TICK_W'(hi);
    lv.val = base_tick + TICK_W'(lo);
    lv.empty = 1'b0;
    queue_levels(lv);
  endfunction

  function int check_levels(logic [63:0] tdata, logic [1:0] tuser);
    levels_t lv;
    int bad;
    bad = 0;
    if (pending_levels.size() == 0) begin
      $display("%0t unexpected word tdata=%h tuser=%b", $time, tdata, tuser);
      return 1;
    end
    lv = pending_levels.pop_front();
    if (tdata[19:0] !== lv.poc) begin
      $display("%0t poc_tick exp=%0d got=%0d", $time, lv.poc, tdata[19:0]);
      bad++;
    end
    if (tdata[39:20] !== lv.vah) begin
      $display("%0t vah_tick exp=%0d got=%0d", $time, lv.vah, tdata[39:20]);
      bad++;
    end
    if (tdata[59:40] !== lv.val) begin
      $display("%0t val_tick exp=%0d got=%0d", $time, lv.val, tdata[59:40]);
      bad++;
    end
    if (tdata[63:60] !== 4'd0) begin
      $display("%0t tdata pad exp=0 got=%h", $time, tdata[63:60]);
      bad++;
    end
    if (tuser[0] !== lv.empty) begin
      $display("%0t profile_empty exp=%b got=%b", $time, lv.empty, tuser[0]);
      bad++;
    end
    if (tuser[1] !== lv.oor) begin
      $display("%0t out_of_range exp=%b got=%b", $time, lv.oor, tuser[1]);
      bad++;
    end
    return (bad != 0) ? 1 : 0;
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD      = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // close_tick[19:0], bar_volume[43:20], zero
  logic [0:0]  s_axis_tuser_i = '0;   // new_session[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;        // poc_tick[19:0], vah_tick[39:20], val_tick[59:40]
  logic [1:0]  m_axis_tuser_o;        // profile_empty[0], out_of_range[1]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;

  profile_scoreboard sb = new();
  int fails = 0;
  int send_pct = 0;      // sender idle chance per cycle
  int recv_pct = 0;      // receiver stall chance per cycle
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  volume_profile_value_area_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // result side: check accepted words, then pick next tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        fails += sb.check_levels(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("volume_profile_value_area_core: mismatch");
      $finish;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [19:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_bar(bit ns, logic [19:0] tick, logic [23:0] vol);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= ns;
    s_axis_tdata_i  <= {4'd0, vol, tick};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_bar(ns, tick, vol);
    if ($urandom_range(0, 99) < send_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_pct);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // random bar mostly near the window base so the value area has shape
  task automatic send_random_bar();
    logic [19:0] tick, base;
    logic [23:0] vol;
    int          sel;
    bit          ns;
    base = sb.base_tick;
    sel = $urandom_range(0, 99);
    if (sel < 70)      tick = base + 20'($urandom_range(0, 31));
    else if (sel < 80) tick = base + 20'($urandom_range(0, 1023));
    else if (sel < 90) tick = base + 20'(1024 + $urandom_range(0, 2000));
    else if (sel < 95) tick = base - 20'($urandom_range(1, 50));
    else               tick = 20'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 20)      vol = '0;
    else if (sel < 60) vol = 24'($urandom_range(1, 1000));
    else               vol = 24'($urandom);
    ns = ($urandom_range(0, 19) == 0);
    send_bar(ns, tick, vol);
  endtask

  task automatic random_phase(logic [10:0] q, logic [19:0] base, int n, int sp, int rp);
    write_cfg(CFG_VALUE_AREA, {9'd0, q});
    write_cfg(CFG_PRICE_BASE, base);
    send_pct = sp;
    recv_pct = rp;
    send_bar(1'b1, base + 20'($urandom_range(0, 31)), 24'($urandom));
    repeat (n - 1) send_random_bar();
    drain();
  endtask

  initial begin
    sb.reset_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing pass after reset
    repeat (1100) @(posedge clk_i);

    // directed: ties, window edges, empty profile, out of window, full volume
    write_cfg(CFG_VALUE_AREA, 20'd717);
    write_cfg(CFG_PRICE_BASE, 20'd0);
    send_bar(1'b1, 20'd0, 24'd0);           // zero volume only, empty profile
    send_bar(1'b0, 20'd1024, 24'd7);        // just past the window, still empty
    send_bar(1'b0, 20'd5, 24'd100);
    send_bar(1'b0, 20'd3, 24'd100);         // tie, lower tick wins
    send_bar(1'b0, 20'd1023, 24'd0);        // top bin marked, no volume
    send_bar(1'b0, 20'd7, 24'd100);         // third equal bin, lower tick still wins
    send_bar(1'b0, 20'd0, 24'hFFFFFF);
    send_bar(1'b0, 20'hFFFFF, 24'd9);
    send_bar(1'b1, 20'd10, 24'd0);          // new session, empty again
    send_bar(1'b0, 20'd11, 24'hFFFFFF);
    send_bar(1'b0, 20'd9, 24'd50);
    send_bar(1'b0, 20'd12, 24'd50);
    drain();
    write_cfg(CFG_VALUE_AREA, 20'd0);       // fraction zero: poc alone
    send_bar(1'b0, 20'd20, 24'd1);
    send_bar(1'b0, 20'd1023, 24'd500);
    drain();
    write_cfg(CFG_VALUE_AREA, 20'd2047);    // unreachable target: every marked tick
    send_bar(1'b0, 20'd2, 24'd3);
    send_bar(1'b0, 20'd1023, 24'd1);
    drain();
    write_cfg(CFG_VALUE_AREA, 20'd1024);
    write_cfg(CFG_PRICE_BASE, 20'hFFC00);   // window ends at the top tick
    send_bar(1'b1, 20'hFFFFF, 24'hABCDEF);
    send_bar(1'b0, 20'hFFC00, 24'h123456);
    send_bar(1'b0, 20'hFFBFF, 24'd1);       // one below the base
    send_bar(1'b0, 20'd0, 24'd1);
    drain();

    // long receiver hold while bars keep coming
    hold_req = 1;
    random_phase(11'd717, 20'd0, 60, 0, 0);
    random_phase(11'd2047, 20'd1047900, 58, 50, 0);
    random_phase(11'd0, 20'($urandom), 58, 0, 50);
    random_phase(11'd1024, 20'd500000, 58, 8, 8);
    random_phase(11'($urandom_range(0, 1024)), 20'($urandom), 56, 0, 0);

    if (fails == 0) $display("volume_profile_value_area_core: match");
    else $display("volume_profile_value_area_core: mismatch");
    $finish;
  end
endmodule

FILE: volume_profile_value_area_core.f
rtl/vpva_pkg.sv
rtl/vpva_ctrl.sv
rtl/vpva_dp.sv
rtl/volume_profile_value_area_core.sv
verif/tb_top.sv
